// File: sv/jnps_pkg.sv
// Shared types and constants for the nine-point Jacobi stencil sweep core.
package jnps_pkg;

    // Configuration port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_X      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Y      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_DIAG   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_GAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

    // Register widths and reset values
    localparam int COEF_W = 32;
    localparam int GW_W   = 11;
    localparam int GH_W   = 13;

    localparam logic signed [COEF_W-1:0] COEF_X_RESET      = 32'sd214748365;
    localparam logic signed [COEF_W-1:0] COEF_Y_RESET      = 32'sd214748365;
    localparam logic signed [COEF_W-1:0] COEF_DIAG_RESET   = 32'sd53687091;
    localparam logic signed [COEF_W-1:0] SOURCE_GAIN_RESET = 32'sd0;
    localparam logic [GW_W-1:0]          GRID_WIDTH_RESET  = 11'd1024;
    localparam logic [GH_W-1:0]          GRID_HEIGHT_RESET = 13'd4096;

    // Smallest grid side, border included
    localparam int GRID_MIN = 3;

    // Coefficients are Q2.30
    localparam int FRAC_BITS = 30;

    // Result buffer
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic produce;
        logic last;
    } jnps_tag_t;

endpackage

// File: sv/jnps_line_mem.sv
// Line buffer memory: one synchronous read port, one write port, registered read data.
module jnps_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 96
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/jnps_window.sv
// 3x3 window shift and neighbor pre-sums for the nine-point stencil.
module jnps_window #(
    parameter int SB = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 v_in,
    input  jnps_pkg::jnps_tag_t  tag_in,
    input  logic signed [SB-1:0] above,
    input  logic signed [SB-1:0] mid,
    input  logic signed [SB-1:0] cur,
    input  logic signed [SB-1:0] src_prev,
    output logic                 v_out,
    output jnps_pkg::jnps_tag_t  tag_out,
    output logic signed [SB:0]   sum_x,
    output logic signed [SB:0]   sum_y,
    output logic signed [SB+1:0] sum_diag,
    output logic signed [SB-1:0] centre_src,
    output logic signed [SB-1:0] centre_old
);

    // Column a becomes the left column, column b the centre column after the shift
    logic signed [SB-1:0] col_a_reg [3];
    logic signed [SB-1:0] col_b_reg [3];
    logic signed [SB-1:0] src_lag_reg;

    logic                 v_reg;
    jnps_pkg::jnps_tag_t  tag_reg;
    logic signed [SB:0]   sum_x_reg;
    logic signed [SB:0]   sum_y_reg;
    logic signed [SB+1:0] sum_diag_reg;
    logic signed [SB-1:0] centre_src_reg;
    logic signed [SB-1:0] centre_old_reg;

    logic signed [SB:0]   sum_x_next;
    logic signed [SB:0]   sum_y_next;
    logic signed [SB+1:0] sum_diag_next;

    always_comb
    begin
        sum_x_next    = (SB+1)'(col_a_reg[1]) + (SB+1)'(mid);
        sum_y_next    = (SB+1)'(col_b_reg[0]) + (SB+1)'(col_b_reg[2]);
        sum_diag_next = (SB+2)'(col_a_reg[0]) + (SB+2)'(above)
                      + (SB+2)'(col_a_reg[2]) + (SB+2)'(cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            tag_reg <= '0;
        end
        else
        begin
            v_reg   <= v_in;
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_in)
        begin
            col_a_reg[0]   <= col_b_reg[0];
            col_a_reg[1]   <= col_b_reg[1];
            col_a_reg[2]   <= col_b_reg[2];
            col_b_reg[0]   <= above;
            col_b_reg[1]   <= mid;
            col_b_reg[2]   <= cur;
            src_lag_reg    <= src_prev;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            sum_diag_reg   <= sum_diag_next;
            centre_src_reg <= src_lag_reg;
            centre_old_reg <= col_b_reg[1];
        end
    end

    assign v_out      = v_reg;
    assign tag_out    = tag_reg;
    assign sum_x      = sum_x_reg;
    assign sum_y      = sum_y_reg;
    assign sum_diag   = sum_diag_reg;
    assign centre_src = centre_src_reg;
    assign centre_old = centre_old_reg;

endmodule

// File: sv/jnps_mac.sv
// Weighted sum of the neighbor pre-sums plus the scaled centre source, round half up, saturate to sample range.
module jnps_mac #(
    parameter int SB = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  v_in,
    input  jnps_pkg::jnps_tag_t                   tag_in,
    input  logic signed [SB:0]                    sum_x,
    input  logic signed [SB:0]                    sum_y,
    input  logic signed [SB+1:0]                  sum_diag,
    input  logic signed [SB-1:0]                  centre_src,
    input  logic signed [SB-1:0]                  centre_old,
    input  logic signed [jnps_pkg::COEF_W-1:0]    coef_x,
    input  logic signed [jnps_pkg::COEF_W-1:0]    coef_y,
    input  logic signed [jnps_pkg::COEF_W-1:0]    coef_diag,
    input  logic signed [jnps_pkg::COEF_W-1:0]    source_gain,
    output logic                                  v_out,
    output jnps_pkg::jnps_tag_t                   tag_out,
    output logic signed [SB-1:0]                  q_out,
    output logic signed [SB-1:0]                  old_out
);

    localparam int CW    = jnps_pkg::COEF_W;
    localparam int PX_W  = SB + 1 + CW;
    localparam int PD_W  = SB + 2 + CW;
    localparam int PS_W  = SB + CW;
    localparam int ACC_W = PD_W + 2;
    localparam int Q_W   = ACC_W - jnps_pkg::FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (jnps_pkg::FRAC_BITS - 1);

    // Stage 1: products
    logic                 v1_reg;
    jnps_pkg::jnps_tag_t  tag1_reg;
    logic signed [PX_W-1:0] px_reg;
    logic signed [PX_W-1:0] py_reg;
    logic signed [PD_W-1:0] pd_reg;
    logic signed [PS_W-1:0] ps_reg;
    logic signed [SB-1:0]   old1_reg;

    // Stage 2: accumulated sum with rounding bias
    logic                   v2_reg;
    jnps_pkg::jnps_tag_t    tag2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SB-1:0]   old2_reg;

    // Stage 3: scaled and saturated value
    logic                   v3_reg;
    jnps_pkg::jnps_tag_t    tag3_reg;
    logic signed [SB-1:0]   q_reg;
    logic signed [SB-1:0]   old3_reg;

    logic signed [ACC_W-1:0] acc_next;
    logic signed [Q_W-1:0]   q_full;
    logic [Q_W-SB:0]         q_top;
    logic signed [SB-1:0]    q_next;

    always_comb
    begin
        acc_next = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(pd_reg) + ACC_W'(ps_reg) + ROUND;
    end

    always_comb
    begin
        q_full = acc_reg[ACC_W-1:jnps_pkg::FRAC_BITS];
        q_top  = q_full[Q_W-1:SB-1];
        if ((&q_top) || !(|q_top))
        begin
            q_next = q_full[SB-1:0];
        end
        else
        begin
            q_next = {q_full[Q_W-1], {(SB-1){~q_full[Q_W-1]}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            v1_reg   <= v_in;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= sum_x * coef_x;
        py_reg   <= sum_y * coef_y;
        pd_reg   <= sum_diag * coef_diag;
        ps_reg   <= centre_src * source_gain;
        old1_reg <= centre_old;
        acc_reg  <= acc_next;
        old2_reg <= old1_reg;
        q_reg    <= q_next;
        old3_reg <= old2_reg;
    end

    assign v_out   = v3_reg;
    assign tag_out = tag3_reg;
    assign q_out   = q_reg;
    assign old_out = old3_reg;

endmodule

// File: sv/jnps_out_buf.sv
// Result buffer: small register FIFO between the arithmetic pipeline and the result channel.
module jnps_out_buf #(
    parameter int DW = 95
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic          head_valid,
    output logic [DW-1:0] head_data
);

    logic [DW-1:0]                      slot_reg [jnps_pkg::OUT_DEPTH];
    logic [jnps_pkg::OUT_PTR_W-1:0]     wr_ptr_reg;
    logic [jnps_pkg::OUT_PTR_W-1:0]     rd_ptr_reg;
    logic [jnps_pkg::OUT_CNT_W-1:0]     count_reg;
    logic [jnps_pkg::OUT_CNT_W-1:0]     count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

endmodule

// File: sv/jacobi_nine_point_stencil_sweep_core.sv
// Top level of the nine-point Jacobi stencil sweep core: config, raster counters, datapath.
//
//  channel | signals                                  | direction | beat
//  --------+------------------------------------------+-----------+-------------------------------
//  config  | psel penable pwrite paddr pwdata prdata  | in/out    | one register write or read
//  grid    | grid_valid grid_ready old_value source   | in        | one raster point, border too
//  result  | result_valid result_ready new_value      | out       | one interior point
//          | change max_change last                   |           |
//
//  One grid beat per cycle while grid_ready is high; a result leaves through the window, the
//  arithmetic stages and the result buffer. The line memory is read at the accept edge and
//  written back in the cycle after, so each column is touched once per row with no overlap.
//  An 8-entry result buffer decouples the result channel: grid_ready drops only once 8
//  results are pending, so stalls on the result side hold the grid side after that depth.
//  Reset clears counters, running maximum, pipeline valids and the buffer; the line memory
//  needs no clearing since border rows overwrite it before any interior result reads it.
module jacobi_nine_point_stencil_sweep_core #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jnps_pkg::ADDR_W-1:0]   paddr,
    input  logic [jnps_pkg::DATA_W-1:0]   pwdata,
    output logic [jnps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          grid_valid,
    output logic                          grid_ready,
    input  logic [SAMPLE_BITS-1:0]        old_value,
    input  logic [SAMPLE_BITS-1:0]        source,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [SAMPLE_BITS-1:0]        new_value,
    output logic [SAMPLE_BITS-2:0]        change,
    output logic [SAMPLE_BITS-2:0]        max_change,
    output logic                          last
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int MW     = 3 * SB;
    localparam int RES_W  = SB + 2 * (SB - 1) + 1;
    localparam int PEND_W = jnps_pkg::OUT_CNT_W;
    localparam int COEF_W = jnps_pkg::COEF_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0]       coef_x_reg;
    logic signed [COEF_W-1:0]       coef_y_reg;
    logic signed [COEF_W-1:0]       coef_diag_reg;
    logic signed [COEF_W-1:0]       source_gain_reg;
    logic [jnps_pkg::GW_W-1:0]      grid_width_reg;
    logic [jnps_pkg::GH_W-1:0]      grid_height_reg;

    logic                               cfg_wr;
    logic [jnps_pkg::REG_IDX_W-1:0]     cfg_idx;
    logic                               restart;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[jnps_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && ((cfg_idx == jnps_pkg::REG_GRID_WIDTH) ||
                                (cfg_idx == jnps_pkg::REG_GRID_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg      <= jnps_pkg::COEF_X_RESET;
            coef_y_reg      <= jnps_pkg::COEF_Y_RESET;
            coef_diag_reg   <= jnps_pkg::COEF_DIAG_RESET;
            source_gain_reg <= jnps_pkg::SOURCE_GAIN_RESET;
            grid_width_reg  <= jnps_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= jnps_pkg::GRID_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                jnps_pkg::REG_COEF_X:      coef_x_reg      <= pwdata;
                jnps_pkg::REG_COEF_Y:      coef_y_reg      <= pwdata;
                jnps_pkg::REG_COEF_DIAG:   coef_diag_reg   <= pwdata;
                jnps_pkg::REG_SOURCE_GAIN: source_gain_reg <= pwdata;
                jnps_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[jnps_pkg::GW_W-1:0];
                jnps_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[jnps_pkg::GH_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            jnps_pkg::REG_COEF_X:      prdata = coef_x_reg;
            jnps_pkg::REG_COEF_Y:      prdata = coef_y_reg;
            jnps_pkg::REG_COEF_DIAG:   prdata = coef_diag_reg;
            jnps_pkg::REG_SOURCE_GAIN: prdata = source_gain_reg;
            jnps_pkg::REG_GRID_WIDTH:  prdata = jnps_pkg::DATA_W'(grid_width_reg);
            jnps_pkg::REG_GRID_HEIGHT: prdata = jnps_pkg::DATA_W'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective grid size and raster counters
    // ------------------------------------------------------------------
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb
    begin
        if (32'(grid_width_reg) < 32'(jnps_pkg::GRID_MIN))
        begin
            w_last = CW'(jnps_pkg::GRID_MIN - 1);
        end
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(grid_width_reg - 1'b1);
        end

        if (32'(grid_height_reg) < 32'(jnps_pkg::GRID_MIN))
        begin
            h_last = RW'(jnps_pkg::GRID_MIN - 1);
        end
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = RW'(grid_height_reg - 1'b1);
        end
    end

    logic [CW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;
    logic                 grid_fire;
    jnps_pkg::jnps_tag_t  tag_now;

    assign grid_fire       = grid_valid && grid_ready;
    assign tag_now.produce = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign tag_now.last    = (row_reg == h_last) && (col_reg == w_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (grid_fire)
        begin
            if (col_reg == w_last)
            begin
                col_reg <= '0;
                // wrap the row count at the end of the sweep
                if (row_reg == h_last)
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: {row above, row middle, source of previous row} per column
    // ------------------------------------------------------------------
    logic                 v1_reg;
    jnps_pkg::jnps_tag_t  tag1_reg;
    logic [SB-1:0]        cur1_reg;
    logic [SB-1:0]        src1_reg;
    logic [CW-1:0]        col1_reg;
    logic [MW-1:0]        mem_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            tag1_reg <= '0;
        end
        else
        begin
            v1_reg   <= grid_fire;
            tag1_reg <= tag_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grid_fire)
        begin
            cur1_reg <= old_value;
            src1_reg <= source;
            col1_reg <= col_reg;
        end
    end

    // Write back in the cycle after the read: middle row moves up, current point becomes middle
    jnps_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (MW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (grid_fire),
        .rd_addr (col_reg),
        .rd_data (mem_rd),
        .wr_en   (v1_reg),
        .wr_addr (col1_reg),
        .wr_data ({mem_rd[2*SB-1:SB], cur1_reg, src1_reg})
    );

    // ------------------------------------------------------------------
    // Window and arithmetic
    // ------------------------------------------------------------------
    logic                 v2;
    jnps_pkg::jnps_tag_t  tag2;
    logic signed [SB:0]   sum_x;
    logic signed [SB:0]   sum_y;
    logic signed [SB+1:0] sum_diag;
    logic signed [SB-1:0] centre_src;
    logic signed [SB-1:0] centre_old;

    jnps_window #(
        .SB (SB)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .v_in       (v1_reg),
        .tag_in     (tag1_reg),
        .above      (mem_rd[3*SB-1:2*SB]),
        .mid        (mem_rd[2*SB-1:SB]),
        .cur        (cur1_reg),
        .src_prev   (mem_rd[SB-1:0]),
        .v_out      (v2),
        .tag_out    (tag2),
        .sum_x      (sum_x),
        .sum_y      (sum_y),
        .sum_diag   (sum_diag),
        .centre_src (centre_src),
        .centre_old (centre_old)
    );

    logic                 v5;
    jnps_pkg::jnps_tag_t  tag5;
    logic signed [SB-1:0] q5;
    logic signed [SB-1:0] old5;

    jnps_mac #(
        .SB (SB)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .v_in        (v2),
        .tag_in      (tag2),
        .sum_x       (sum_x),
        .sum_y       (sum_y),
        .sum_diag    (sum_diag),
        .centre_src  (centre_src),
        .centre_old  (centre_old),
        .coef_x      (coef_x_reg),
        .coef_y      (coef_y_reg),
        .coef_diag   (coef_diag_reg),
        .source_gain (source_gain_reg),
        .v_out       (v5),
        .tag_out     (tag5),
        .q_out       (q5),
        .old_out     (old5)
    );

    // ------------------------------------------------------------------
    // Change and running maximum
    // ------------------------------------------------------------------
    logic [SB-2:0]  running_max_reg;
    logic [SB:0]    diff_pos;
    logic [SB:0]    diff_neg;
    logic [SB:0]    diff_mag;
    logic [SB-2:0]  chg;
    logic [SB-2:0]  max_next;
    logic           push;

    always_comb
    begin
        diff_pos = {q5[SB-1], q5} - {old5[SB-1], old5};
        diff_neg = {old5[SB-1], old5} - {q5[SB-1], q5};
        diff_mag = diff_pos[SB] ? diff_neg : diff_pos;
        // clamp to the largest positive sample
        if (diff_mag[SB] || diff_mag[SB-1])
        begin
            chg = '1;
        end
        else
        begin
            chg = diff_mag[SB-2:0];
        end
        max_next = (chg > running_max_reg) ? chg : running_max_reg;
    end

    assign push = v5 && tag5.produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_max_reg <= '0;
        end
        else if (restart)
        begin
            running_max_reg <= '0;
        end
        else if (push)
        begin
            // drop the maximum once the sweep's final point is out
            running_max_reg <= tag5.last ? '0 : max_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer and credit count
    // ------------------------------------------------------------------
    logic [RES_W-1:0]  head_data;
    logic              result_fire;
    logic [PEND_W-1:0] pending_reg;
    logic              pend_inc;

    assign result_fire = result_valid && result_ready;
    assign pend_inc    = grid_fire && tag_now.produce;

    jnps_out_buf #(
        .DW (RES_W)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({q5, chg, max_next, tag5.last}),
        .pop        (result_fire),
        .head_valid (result_valid),
        .head_data  (head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (pend_inc && !result_fire)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (result_fire && !pend_inc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    assign grid_ready = (pending_reg < PEND_W'(jnps_pkg::OUT_DEPTH));

    assign new_value  = head_data[RES_W-1 -: SB];
    assign change     = head_data[2*(SB-1) : SB];
    assign max_change = head_data[SB-1:1];
    assign last       = head_data[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(jnps_pkg::OUT_DEPTH))
        else $error("pending result count above buffer depth");

    a_result_backed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != '0))
        else $error("result presented with no pending credit");

    a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (push && tag5.last) |=> (running_max_reg == '0))
        else $error("running maximum not cleared after sweep end");

    a_sweep_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_fire && tag_now.last && !restart) |=> (col_reg == '0) && (row_reg == '0))
        else $error("raster counters not wrapped at sweep end");

endmodule
